>>> sv/jfd_pkg.sv
// ----------------------------------------------------------------------------
// jfd_pkg
// Shared types and constants of the serial frame decoder.
// ----------------------------------------------------------------------------
package jfd_pkg;

    localparam int unsigned BYTE_W = 8;

    localparam logic [BYTE_W-1:0] SYNC_RESET   = 8'hE0;
    localparam logic [BYTE_W-1:0] ESCAPE_RESET = 8'hD0;

    typedef enum logic {
        REG_SYNC   = 1'b0,
        REG_ESCAPE = 1'b1
    } t_reg_idx;

    typedef enum logic [2:0] {
        PH_HUNT = 3'd0,
        PH_DEST = 3'd1,
        PH_SIZE = 3'd2,
        PH_DATA = 3'd3,
        PH_ESC  = 3'd4
    } t_phase;

    typedef struct packed {
        logic [BYTE_W-1:0] payload_byte;
        logic [BYTE_W-1:0] dest_addr;
        logic [BYTE_W-1:0] byte_index;
        logic              last_of_frame;
        logic              empty_frame;
    } t_result;

    typedef struct packed {
        logic [BYTE_W-1:0] sync_code;
        logic [BYTE_W-1:0] escape_code;
    } t_codes;

endpackage

>>> sv/jfd_cfg_regs.sv
// ----------------------------------------------------------------------------
// jfd_cfg_regs
// Write-only register file holding the sync and escape codes.
// ----------------------------------------------------------------------------
module jfd_cfg_regs (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  jfd_pkg::t_reg_idx  i_cfg_idx,
    input  logic [7:0]         i_cfg_data,
    output jfd_pkg::t_codes    o_codes
);
    import jfd_pkg::*;

    logic [BYTE_W-1:0] r_sync;
    logic [BYTE_W-1:0] r_escape;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync   <= SYNC_RESET;
            r_escape <= ESCAPE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_SYNC: begin
                    r_sync <= i_cfg_data;
                end
                REG_ESCAPE: begin
                    r_escape <= i_cfg_data;
                end
                default: begin
                    r_sync <= r_sync;
                end
            endcase
        end
    end

    assign o_codes.sync_code   = r_sync;
    assign o_codes.escape_code = r_escape;

endmodule

>>> sv/jfd_parser.sv
// ----------------------------------------------------------------------------
// jfd_parser
// Frame state machine: sync hunt, header capture, unescaping and indexing.
// ----------------------------------------------------------------------------
module jfd_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [7:0]        i_byte,
    input  jfd_pkg::t_codes   i_codes,
    output logic              o_res_valid,
    output jfd_pkg::t_result  o_res
);
    import jfd_pkg::*;

    t_phase            r_phase;
    t_phase            n_phase;
    logic [BYTE_W-1:0] r_dest;
    logic [BYTE_W-1:0] n_dest;
    logic [BYTE_W-1:0] r_left;
    logic [BYTE_W-1:0] n_left;
    logic [BYTE_W-1:0] r_index;
    logic [BYTE_W-1:0] n_index;

    logic [BYTE_W-1:0] size_m1;
    logic [BYTE_W-1:0] left_m1;
    logic              is_escape;

    assign size_m1   = i_byte - 8'd1;
    assign left_m1   = r_left - 8'd1;
    assign is_escape = (i_byte == i_codes.escape_code);

    // next state
    always_comb begin
        n_phase = r_phase;
        case (r_phase)
            PH_HUNT: begin
                if (i_byte == i_codes.sync_code) begin
                    n_phase = PH_DEST;
                end
            end
            PH_DEST: begin
                n_phase = PH_SIZE;
            end
            PH_SIZE: begin
                n_phase = (size_m1 == '0) ? PH_HUNT : PH_DATA;
            end
            PH_DATA: begin
                if (is_escape) begin
                    n_phase = PH_ESC;
                end else begin
                    n_phase = (left_m1 == '0) ? PH_HUNT : PH_DATA;
                end
            end
            PH_ESC: begin
                n_phase = (left_m1 == '0) ? PH_HUNT : PH_DATA;
            end
            default: begin
                n_phase = PH_HUNT;
            end
        endcase
    end

    // outputs and frame counters
    always_comb begin
        n_dest                 = r_dest;
        n_left                 = r_left;
        n_index                = r_index;
        o_res_valid            = 1'b0;
        o_res.payload_byte     = i_byte;
        o_res.dest_addr        = r_dest;
        o_res.byte_index       = r_index;
        o_res.last_of_frame    = (left_m1 == '0);
        o_res.empty_frame      = 1'b0;
        case (r_phase)
            PH_DEST: begin
                n_dest = i_byte;
            end
            PH_SIZE: begin
                n_left              = size_m1;
                n_index             = '0;
                o_res_valid         = (size_m1 == '0);
                o_res.payload_byte  = '0;
                o_res.byte_index    = '0;
                o_res.last_of_frame = 1'b1;
                o_res.empty_frame   = 1'b1;
            end
            PH_DATA: begin
                if (!is_escape) begin
                    n_left      = left_m1;
                    n_index     = r_index + 8'd1;
                    o_res_valid = 1'b1;
                end
            end
            PH_ESC: begin
                n_left             = left_m1;
                n_index            = r_index + 8'd1;
                o_res_valid        = 1'b1;
                o_res.payload_byte = i_byte + 8'd1;
            end
            default: begin
                o_res_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_dest  <= '0;
            r_left  <= '0;
            r_index <= '0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_dest  <= n_dest;
            r_left  <= n_left;
            r_index <= n_index;
        end
    end

    a_no_result_while_hunting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_HUNT) |-> !o_res_valid)
        else $error("result produced while hunting for sync");

    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.empty_frame) |-> o_res.last_of_frame)
        else $error("empty frame result not marked last");

    a_last_returns_to_hunt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && o_res_valid && o_res.last_of_frame) |=> (r_phase == PH_HUNT))
        else $error("decoder did not resume hunting after last byte");

    a_escape_enters_esc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && r_phase == PH_DATA && is_escape) |=> (r_phase == PH_ESC))
        else $error("escape byte did not enter escape phase");

endmodule

>>> sv/jvs_frame_decoder.sv
// ----------------------------------------------------------------------------
// jvs_frame_decoder
// Serial frame decoder: received bytes in, unescaped payload bytes out.
// ----------------------------------------------------------------------------
// One received byte is accepted per clock. The frame state machine decides
// on each byte in the cycle it is accepted and loads any result into a single
// output register, so a result appears in the cycle after its byte. The input is
// ready whenever that register is empty or being drained, so with the output
// side always ready the block sustains one byte per cycle; it stalls only
// while a held result waits on the output.
module jvs_frame_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config write port: index 0 sync code, 1 escape code
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [7:0]  i_cfg_data,
    // input stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,    // [7:0] rx_byte
    // result stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,    // [7:0] payload_byte, [15:8] dest_addr,
                                           // [23:16] byte_index
    output logic        o_m_axis_tlast,    // last_of_frame
    output logic        o_m_axis_tuser     // empty_frame
);
    import jfd_pkg::*;

    t_codes  codes;
    t_result res;
    logic    res_valid;
    logic    accept;
    t_reg_idx cfg_idx;

    t_result r_out;
    logic    r_out_valid;

    assign cfg_idx = t_reg_idx'(i_cfg_idx);

    jfd_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_codes    (codes)
    );

    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    jfd_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_byte      (i_s_axis_tdata),
        .i_codes     (codes),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_out_valid <= accept && res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && res_valid) begin
            r_out <= res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out.byte_index, r_out.dest_addr, r_out.payload_byte};
    assign o_m_axis_tlast  = r_out.last_of_frame;
    assign o_m_axis_tuser  = r_out.empty_frame;

endmodule
